// ===== rtl/cnt_pkg.sv =====
// Package for the Carmichael number test block: widths, controller states, command/status types.
// No dependencies.
`default_nettype none
package cnt_pkg;
    localparam int NUM_WIDTH_DEF = 16;

    typedef enum logic [3:0] {
        S_IDLE, S_PR_DIV, S_PR_WAIT, S_CM_GCD, S_CM_GCDW, S_CM_POW, S_CM_POWW, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_PR_STEP, OP_GCD_START, OP_GCD_STEP, OP_POW_START, OP_POW_STEP,
        OP_NEXT_BASE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mod_busy;
        logic pr_done;
        logic pr_prime;
        logic gcd_done;
        logic gcd_one;
        logic pow_done;
        logic pow_one;
        logic base_last;
        logic carm_skip;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/carmichael_number_test_top.sv =====
// Top level of the Carmichael number test: controller plus arithmetic datapath.
// Depends on cnt_pkg, cnt_ctrl, cnt_dp, cnt_mod.
//   channel | signals                                | dir
//   input   | i_valid, o_stall, i_n_value            | in
//   output  | o_valid, i_stall, o_prime_flag, o_carmichael_flag | out
// One request at a time; each modulo step runs in the shared divider.
// Trial division runs up to sqrt(n)/2 steps; the Carmichael pass runs one gcd and, for coprime
// bases, about 2*NUM_WIDTH modular products per base, up to n-2 bases.
// Reset is synchronous; the result register holds while i_stall is high.
`default_nettype none
module carmichael_number_test_top import cnt_pkg::*; #(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [NUM_WIDTH-1:0] i_n_value,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_prime_flag,
    output logic                      o_carmichael_flag
);
    t_cmd    cmd;
    t_status status;

    cnt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_stall          (i_stall),
        .i_status         (status),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_prime_flag     (o_prime_flag),
        .o_carmichael_flag(o_carmichael_flag),
        .o_cmd            (cmd)
    );

    cnt_dp #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n_value(i_n_value),
        .i_cmd    (cmd),
        .o_status (status)
    );
endmodule
`default_nettype wire

// ===== rtl/cnt_mod.sv =====
// Shared modulo unit: restoring division remainder, one quotient bit per cycle.
// Depends on cnt_pkg.
`default_nettype none
module cnt_mod import cnt_pkg::*; #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_busy,
    output logic [W-1:0]      o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_den;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    n_shift;

    assign n_shift = {r_rem[W-1:0], r_num[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[W-2:0], 1'b0};
            if (n_shift >= {1'b0, r_den}) begin
                r_rem <= n_shift - {1'b0, r_den};
            end else begin
                r_rem <= n_shift;
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[W-1:0];
endmodule
`default_nettype wire

// ===== rtl/cnt_dp.sv =====
// Datapath: trial division, Euclid gcd and square-and-multiply, all on the shared modulo unit.
// Depends on cnt_pkg and cnt_mod.
`default_nettype none
module cnt_dp import cnt_pkg::*; #(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [NUM_WIDTH-1:0] i_n_value,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status
);
    localparam int W  = 2 * NUM_WIDTH;
    localparam int PW = 3;

    typedef enum logic [PW-1:0] {
        P_D2, P_D3, P_D5, P_ODD, P_MUL_ACC, P_MUL_SQ
    } t_phase;

    logic [NUM_WIDTH-1:0] r_n;
    logic [NUM_WIDTH-1:0] r_d;
    logic [NUM_WIDTH-1:0] r_a;
    logic [NUM_WIDTH-1:0] r_x;
    logic [NUM_WIDTH-1:0] r_y;
    logic [NUM_WIDTH-1:0] r_acc;
    logic [NUM_WIDTH-1:0] r_b;
    logic [NUM_WIDTH-1:0] r_e;
    logic                 r_pend;
    logic                 r_prime;
    logic                 r_pr_done;
    logic                 r_gcd_done;
    logic                 r_pow_done;
    t_phase               r_phase;
    logic                 r_prod_v;

    logic                 n_start;
    logic [W-1:0]         n_num;
    logic [W-1:0]         n_den;
    logic                 m_busy;
    logic [W-1:0]         m_rem;
    logic [NUM_WIDTH-1:0] rem_s;
    logic [W-1:0]         d_sq;
    logic [W-1:0]         prod;

    assign rem_s = m_rem[NUM_WIDTH-1:0];
    assign d_sq  = W'(r_d) * W'(r_d);

    cnt_mod #(.W(W)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(n_start),
        .i_num  (n_num),
        .i_den  (n_den),
        .o_busy (m_busy),
        .o_rem  (m_rem)
    );

    logic [W-1:0] r_prod;

    always_comb begin
        prod    = W'(r_acc) * W'(r_b);
        if (r_phase == P_MUL_SQ) begin
            prod = W'(r_b) * W'(r_b);
        end
        n_start = 1'b0;
        n_num   = W'(r_n);
        n_den   = W'(r_d);
        case (i_cmd.op)
            OP_PR_STEP: begin
                n_start = r_pend;
                n_num   = W'(r_n);
                n_den   = W'(r_d);
            end
            OP_GCD_STEP: begin
                n_start = r_pend;
                n_num   = W'(r_x);
                n_den   = W'(r_y);
            end
            OP_POW_STEP: begin
                n_start = r_pend;
                n_num   = r_prod;
                n_den   = W'(r_n);
            end
            default: begin
                n_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_pr_done  <= 1'b0;
            r_gcd_done <= 1'b0;
            r_pow_done <= 1'b0;
            r_prime    <= 1'b0;
            r_phase    <= P_D2;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_n       <= i_n_value;
                    r_d       <= NUM_WIDTH'(2);
                    r_phase   <= P_D2;
                    r_pr_done <= 1'b0;
                    r_prime   <= 1'b0;
                    r_a       <= NUM_WIDTH'(2);
                    if (i_n_value < NUM_WIDTH'(2)) begin
                        r_pr_done <= 1'b1;
                        r_pend    <= 1'b0;
                    end else begin
                        r_pend <= 1'b1;
                    end
                end
                OP_PR_STEP: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                    end else if (!m_busy && !r_pr_done) begin
                        if (r_phase == P_ODD && d_sq > W'(r_n)) begin
                            r_prime   <= 1'b1;
                            r_pr_done <= 1'b1;
                        end else if (rem_s == '0) begin
                            r_prime   <= (r_phase != P_ODD) && (r_n == r_d);
                            r_pr_done <= 1'b1;
                        end else begin
                            r_pend <= 1'b1;
                            case (r_phase)
                                P_D2: begin
                                    r_phase <= P_D3;
                                    r_d     <= NUM_WIDTH'(3);
                                end
                                P_D3: begin
                                    r_phase <= P_D5;
                                    r_d     <= NUM_WIDTH'(5);
                                end
                                P_D5: begin
                                    r_phase <= P_ODD;
                                    r_d     <= NUM_WIDTH'(7);
                                end
                                default: begin
                                    r_d <= r_d + NUM_WIDTH'(2);
                                end
                            endcase
                            if (r_phase == P_ODD && d_sq + (W'(r_d) << 2) + W'(4) > W'(r_n)) begin
                                r_prime   <= 1'b1;
                                r_pr_done <= 1'b1;
                                r_pend    <= 1'b0;
                            end else if (r_phase == P_D5 && W'(49) > W'(r_n)) begin
                                r_prime   <= 1'b1;
                                r_pr_done <= 1'b1;
                                r_pend    <= 1'b0;
                            end
                        end
                    end
                end
                OP_GCD_START: begin
                    r_x        <= r_n;
                    r_y        <= r_a;
                    r_pend     <= 1'b1;
                    r_gcd_done <= 1'b0;
                end
                OP_GCD_STEP: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                    end else if (!m_busy && !r_gcd_done) begin
                        if (r_y == '0) begin
                            r_gcd_done <= 1'b1;
                        end else begin
                            r_x    <= r_y;
                            r_y    <= rem_s;
                            r_pend <= 1'b1;
                        end
                    end
                end
                OP_POW_START: begin
                    r_acc      <= NUM_WIDTH'(1);
                    r_b        <= r_a;
                    r_e        <= r_n - NUM_WIDTH'(1);
                    r_pow_done <= 1'b0;
                    r_phase    <= P_MUL_ACC;
                    r_pend     <= 1'b0;
                end
                OP_POW_STEP: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                    end else if (!m_busy && !r_pow_done) begin
                        if (r_phase == P_MUL_ACC && r_prod_v) begin
                            r_acc   <= rem_s;
                            r_phase <= P_MUL_SQ;
                        end else if (r_phase == P_MUL_SQ && r_prod_v) begin
                            r_b     <= rem_s;
                            r_e     <= r_e >> 1;
                            r_phase <= P_MUL_ACC;
                        end else if (r_e == '0) begin
                            r_pow_done <= 1'b1;
                        end else if (r_phase == P_MUL_ACC && !r_e[0]) begin
                            r_phase <= P_MUL_SQ;
                        end else begin
                            r_pend <= 1'b1;
                        end
                    end
                end
                OP_NEXT_BASE: begin
                    r_a <= r_a + NUM_WIDTH'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // product register feeds the modulo unit; valid marks a pending product result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod <= prod;
            if (i_cmd.op != OP_POW_STEP) begin
                r_prod_v <= 1'b0;
            end else if (r_pend) begin
                r_prod_v <= 1'b1;
            end else if (!m_busy && r_prod_v) begin
                r_prod_v <= 1'b0;
            end
        end
    end

    assign o_status.mod_busy  = m_busy | r_pend;
    assign o_status.pr_done   = r_pr_done;
    assign o_status.pr_prime  = r_prime;
    assign o_status.gcd_done  = r_gcd_done;
    assign o_status.gcd_one   = (r_x == NUM_WIDTH'(1));
    assign o_status.pow_done  = r_pow_done;
    assign o_status.pow_one   = (r_acc == NUM_WIDTH'(1));
    assign o_status.base_last = (r_a >= r_n - NUM_WIDTH'(1));
    assign o_status.carm_skip = r_prime | (r_n < NUM_WIDTH'(2));
endmodule
`default_nettype wire

// ===== rtl/cnt_ctrl.sv =====
// Controller state machine: sequences primality, then gcd and Fermat power per base.
// Depends on cnt_pkg.
`default_nettype none
module cnt_ctrl import cnt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output logic         o_stall,
    output logic         o_valid,
    output logic         o_prime_flag,
    output logic         o_carmichael_flag,
    output t_cmd         o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   r_prime;
    logic   r_carm;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_PR_DIV;
            S_PR_DIV:  n_state = S_PR_WAIT;
            S_PR_WAIT: begin
                if (i_status.pr_done) begin
                    if (i_status.carm_skip || i_status.base_last) n_state = S_DONE;
                    else n_state = S_CM_GCD;
                end
            end
            S_CM_GCD:  n_state = S_CM_GCDW;
            S_CM_GCDW: begin
                if (i_status.gcd_done) begin
                    if (i_status.gcd_one) n_state = S_CM_POW;
                    else if (i_status.base_last) n_state = S_DONE;
                    else n_state = S_CM_GCD;
                end
            end
            S_CM_POW:  n_state = S_CM_POWW;
            S_CM_POWW: begin
                if (i_status.pow_done) begin
                    if (!i_status.pow_one || i_status.base_last) n_state = S_DONE;
                    else n_state = S_CM_GCD;
                end
            end
            S_DONE:    if (!r_valid) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE:    if (i_valid) o_cmd.op = OP_LOAD;
            S_PR_DIV,
            S_PR_WAIT: o_cmd.op = OP_PR_STEP;
            S_CM_GCD:  o_cmd.op = OP_GCD_START;
            S_CM_GCDW: begin
                o_cmd.op = OP_GCD_STEP;
                if (i_status.gcd_done && !i_status.gcd_one) o_cmd.op = OP_NEXT_BASE;
            end
            S_CM_POW:  o_cmd.op = OP_POW_START;
            S_CM_POWW: begin
                o_cmd.op = OP_POW_STEP;
                if (i_status.pow_done) o_cmd.op = OP_NEXT_BASE;
            end
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_prime <= 1'b0;
            r_carm  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            if (r_state == S_PR_WAIT && i_status.pr_done && n_state == S_DONE) begin
                r_prime <= i_status.pr_prime;
                r_carm  <= !i_status.carm_skip;
            end else if (r_state == S_PR_WAIT && i_status.pr_done) begin
                r_prime <= i_status.pr_prime;
                r_carm  <= 1'b1;
            end
            if (r_state == S_CM_POWW && i_status.pow_done && !i_status.pow_one) r_carm <= 1'b0;
            if (r_state != S_DONE && n_state == S_DONE) r_valid <= 1'b1;
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_prime_flag      = r_prime;
    assign o_carmichael_flag = r_carm;
endmodule
`default_nettype wire

// ===== rtl/cnt_chk.sv =====
// Port checker for the Carmichael number test top, attached by bind.
// Depends on cnt_pkg.
`default_nettype none
module cnt_chk import cnt_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_prime_flag,
    input wire logic o_carmichael_flag
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_prime_flag && o_carmichael_flag && o_valid))
        else $error("prime and carmichael both set");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prime_flag))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted a request without going busy");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind carmichael_number_test_top cnt_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_prime_flag     (o_prime_flag),
    .o_carmichael_flag(o_carmichael_flag)
);
`default_nettype wire
